FILE: src/sisbl_pkg.sv
package sisbl_pkg;

    localparam int TAG_W = 8;
    localparam int LEN_W = 6;

    // controller to datapath
    typedef struct packed {
        logic load_in;    // latch accepted request fields
        logic set_drop;   // list full, request dropped
        logic load_pos;   // pos <= entry count
        logic rd_pos;     // read entry pos-1
        logic shift;      // mem[pos] <= read data, pos--
        logic wr_new;     // mem[pos] <= new word, count++
        logic rd_k;       // read entry k for output
        logic inc_k;      // advance output index
        logic clr_run;    // empty list, clear flag and index
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic pos_zero;
        logic less;       // new length below read entry length
        logic last;
        logic end_k;      // output index is on final entry
    } dp_stat_t;

endpackage

FILE: src/stable_insertion_sort_by_length.sv
// Stable insertion sort of words by length.
// Input channel s_*: one request per word (tag, length, last flag). Words are
// inserted into an ascending list; a word goes after stored words of equal
// length. A word arriving with the list full is dropped and sets a sticky
// overflow flag.
// Output channel m_*: after a request with last_word set, every stored entry
// is sent in sorted order, end_of_list on the final one, overflowed on all.
// The list and flag are then cleared.
// Sequence: an accepted word is latched, then each stored entry it moves past
// takes a read step (ST_RD) and a shift step (ST_CMP), and a last read and
// compare writes the word before s_ready returns. The single-port list
// memory, one read and one write per compare/shift step, sets this. Each
// result takes a memory read (ST_ERD), then m_valid (ST_EOUT).
// s_ready is low while a word is inserted or a run drains. A stalled
// receiver holds the current result on m_* until m_ready; nothing is lost.
// Reset (aresetn low, synchronous) empties the list, clears the overflow
// flag and returns to accepting input. No clearing pass is needed.
module stable_insertion_sort_by_length #(
    parameter int MAX_WORDS = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [sisbl_pkg::TAG_W-1:0]  s_word_tag,
    input  logic [sisbl_pkg::LEN_W-1:0]  s_word_length,
    input  logic                         s_last_word,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [sisbl_pkg::TAG_W-1:0]  m_sorted_tag,
    output logic [sisbl_pkg::LEN_W-1:0]  m_sorted_length,
    output logic                         m_end_of_list,
    output logic                         m_overflowed
);
    sisbl_pkg::dp_cmd_t  cmd;
    sisbl_pkg::dp_stat_t stat;

    sisbl_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .s_last_word (s_last_word),
        .stat        (stat),
        .cmd         (cmd)
    );

    sisbl_datapath #(
        .MAX_WORDS (MAX_WORDS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_word_tag      (s_word_tag),
        .s_word_length   (s_word_length),
        .s_last_word     (s_last_word),
        .cmd             (cmd),
        .stat            (stat),
        .m_sorted_tag    (m_sorted_tag),
        .m_sorted_length (m_sorted_length),
        .m_end_of_list   (m_end_of_list),
        .m_overflowed    (m_overflowed)
    );

endmodule

FILE: src/sisbl_datapath.sv
module sisbl_datapath #(
    parameter int MAX_WORDS = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [sisbl_pkg::TAG_W-1:0]  s_word_tag,
    input  logic [sisbl_pkg::LEN_W-1:0]  s_word_length,
    input  logic                         s_last_word,
    input  sisbl_pkg::dp_cmd_t           cmd,
    output sisbl_pkg::dp_stat_t          stat,
    output logic [sisbl_pkg::TAG_W-1:0]  m_sorted_tag,
    output logic [sisbl_pkg::LEN_W-1:0]  m_sorted_length,
    output logic                         m_end_of_list,
    output logic                         m_overflowed
);
    localparam int ADDR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CNT_W  = $clog2(MAX_WORDS + 1);
    localparam int ENT_W  = sisbl_pkg::TAG_W + sisbl_pkg::LEN_W;

    logic [ENT_W-1:0]  mem [MAX_WORDS];
    logic [ENT_W-1:0]  rd_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              drop_reg;
    logic [ADDR_W-1:0] pos_reg;
    logic [ADDR_W-1:0] k_reg;
    logic [sisbl_pkg::TAG_W-1:0] tag_reg;
    logic [sisbl_pkg::LEN_W-1:0] len_reg;
    logic              last_reg;

    logic [ADDR_W-1:0] rd_addr;
    logic [ENT_W-1:0]  wr_data;

    assign rd_addr = cmd.rd_k ? k_reg : (pos_reg - ADDR_W'(1));
    assign wr_data = cmd.shift ? rd_reg : {tag_reg, len_reg};

    always_ff @(posedge aclk) begin
        if (cmd.shift || cmd.wr_new) begin
            mem[pos_reg] <= wr_data;
        end
        if (cmd.rd_pos || cmd.rd_k) begin
            rd_reg <= mem[rd_addr];
        end
        if (cmd.load_in) begin
            tag_reg  <= s_word_tag;
            len_reg  <= s_word_length;
            last_reg <= s_last_word;
        end
        if (cmd.load_pos) begin
            pos_reg <= count_reg[ADDR_W-1:0];
        end else if (cmd.shift) begin
            pos_reg <= pos_reg - ADDR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            drop_reg  <= 1'b0;
            k_reg     <= '0;
        end else begin
            if (cmd.clr_run) begin
                count_reg <= '0;
                drop_reg  <= 1'b0;
                k_reg     <= '0;
            end else begin
                if (cmd.wr_new)   count_reg <= count_reg + CNT_W'(1);
                if (cmd.set_drop) drop_reg  <= 1'b1;
                if (cmd.inc_k)    k_reg     <= k_reg + ADDR_W'(1);
            end
        end
    end

    assign stat.full     = (count_reg >= CNT_W'(MAX_WORDS));
    assign stat.pos_zero = (pos_reg == '0);
    assign stat.less     = (len_reg < rd_reg[sisbl_pkg::LEN_W-1:0]);
    assign stat.last     = last_reg;
    assign stat.end_k    = ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);

    assign m_sorted_tag    = rd_reg[ENT_W-1:sisbl_pkg::LEN_W];
    assign m_sorted_length = rd_reg[sisbl_pkg::LEN_W-1:0];
    assign m_end_of_list   = stat.end_k;
    assign m_overflowed    = drop_reg;

endmodule

FILE: src/sisbl_ctrl.sv
module sisbl_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  logic                 s_last_word,
    input  sisbl_pkg::dp_stat_t  stat,
    output sisbl_pkg::dp_cmd_t   cmd
);
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RD   = 5'b00010,
        ST_CMP  = 5'b00100,
        ST_ERD  = 5'b01000,
        ST_EOUT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_EOUT);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    if (stat.full) begin
                        cmd.set_drop = 1'b1;
                        state_next   = s_last_word ? ST_ERD : ST_IDLE;
                    end else begin
                        cmd.load_pos = 1'b1;
                        state_next   = ST_RD;
                    end
                end
            end
            ST_RD: begin
                cmd.rd_pos = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                // bound checked first; read data is stale when pos is zero
                if (!stat.pos_zero && stat.less) begin
                    cmd.shift  = 1'b1;
                    state_next = ST_RD;
                end else begin
                    cmd.wr_new = 1'b1;
                    state_next = stat.last ? ST_ERD : ST_IDLE;
                end
            end
            ST_ERD: begin
                cmd.rd_k   = 1'b1;
                state_next = ST_EOUT;
            end
            ST_EOUT: begin
                if (m_ready) begin
                    if (stat.end_k) begin
                        cmd.clr_run = 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        cmd.inc_k  = 1'b1;
                        state_next = ST_ERD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/sisbl_checker.sv
module sisbl_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_sorted_tag,
    input logic [5:0] m_sorted_length,
    input logic       m_end_of_list,
    input logic       m_overflowed
);
    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sorted_tag)
            && $stable(m_sorted_length) && $stable(m_end_of_list)
            && $stable(m_overflowed))
        else $error("stalled result changed");

    // input is never taken while a run drains
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("s_ready during output");

    // more results pending: input stays blocked
    a_more: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_end_of_list |=> !s_ready)
        else $error("input accepted mid-run");

    // reset leaves the block ready with no result
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("bad state after reset");

endmodule

bind stable_insertion_sort_by_length sisbl_checker u_sisbl_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_sorted_tag    (m_sorted_tag),
    .m_sorted_length (m_sorted_length),
    .m_end_of_list   (m_end_of_list),
    .m_overflowed    (m_overflowed)
);

FILE: sim/stable_insertion_sort_by_length_tb.sv
`timescale 1ns / 1ps

module stable_insertion_sort_by_length_tb;

    localparam int TAG_W     = sisbl_pkg::TAG_W;
    localparam int LEN_W     = sisbl_pkg::LEN_W;
    localparam int MAX_WORDS = 64;
    localparam int NUM_DIR   = 22;
    localparam int RAND_ITEMS = 345;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 100000;
    localparam int TAIL_CYCLES = 200;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] len;
        logic             eol;
        logic             ovf;
    } sorted_word_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] len;
        logic             last;
        logic             typed;   // expected result given in the row
        sorted_word_t     want;
    } dir_row_t;

    typedef enum int {
        KEY_ANY,
        KEY_TIES,
        KEY_EXTREMES,
        KEY_DESCEND
    } key_mode_e;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [TAG_W-1:0] s_word_tag = '0;
    logic [LEN_W-1:0] s_word_length = '0;
    logic             s_last_word = 1'b0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [TAG_W-1:0] m_sorted_tag;
    logic [LEN_W-1:0] m_sorted_length;
    logic             m_end_of_list;
    logic             m_overflowed;

    // sorted list as the block should hold it
    logic [TAG_W-1:0] list_tag [MAX_WORDS];
    logic [LEN_W-1:0] list_len [MAX_WORDS];
    int               list_cnt = 0;
    bit               list_drop = 1'b0;

    sorted_word_t pending_words[$];
    int           err_cnt = 0;
    int           words_sent = 0;
    int           sender_pace = 1;
    int           sink_pace = 1;
    int           hold_asks = 0;
    int           hold_given = 0;
    int           hold_left = 0;
    int           stall_left = 0;

    dir_row_t dir_rows [NUM_DIR] = '{
        // lone words after an empty list
        '{8'h00, 6'd0,  1'b1, 1'b1, '{8'h00, 6'd0,  1'b1, 1'b0}},
        '{8'hFF, 6'd63, 1'b1, 1'b1, '{8'hFF, 6'd63, 1'b1, 1'b0}},
        '{8'hA5, 6'd42, 1'b1, 1'b1, '{8'hA5, 6'd42, 1'b1, 1'b0}},
        // reversed input, every word moves to the front
        '{8'h01, 6'd40, 1'b0, 1'b0, '0},
        '{8'h02, 6'd30, 1'b0, 1'b0, '0},
        '{8'h03, 6'd20, 1'b0, 1'b0, '0},
        '{8'h04, 6'd10, 1'b0, 1'b0, '0},
        '{8'h05, 6'd0,  1'b1, 1'b0, '0},
        // equal lengths keep arrival order
        '{8'h10, 6'd5,  1'b0, 1'b0, '0},
        '{8'h11, 6'd5,  1'b0, 1'b0, '0},
        '{8'h12, 6'd3,  1'b0, 1'b0, '0},
        '{8'h13, 6'd5,  1'b0, 1'b0, '0},
        '{8'h14, 6'd3,  1'b0, 1'b0, '0},
        '{8'h15, 6'd5,  1'b1, 1'b0, '0},
        // already sorted input
        '{8'h20, 6'd1,  1'b0, 1'b0, '0},
        '{8'h21, 6'd2,  1'b0, 1'b0, '0},
        '{8'h22, 6'd63, 1'b0, 1'b0, '0},
        '{8'h23, 6'd63, 1'b1, 1'b0, '0},
        // extremes interleaved
        '{8'h5A, 6'd63, 1'b0, 1'b0, '0},
        '{8'h3C, 6'd0,  1'b0, 1'b0, '0},
        '{8'hC3, 6'd63, 1'b0, 1'b0, '0},
        '{8'h96, 6'd0,  1'b1, 1'b0, '0}
    };

    stable_insertion_sort_by_length #(
        .MAX_WORDS(MAX_WORDS)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_word_tag     (s_word_tag),
        .s_word_length  (s_word_length),
        .s_last_word    (s_last_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_tag   (m_sorted_tag),
        .m_sorted_length(m_sorted_length),
        .m_end_of_list  (m_end_of_list),
        .m_overflowed   (m_overflowed)
    );

    always #10 aclk = ~aclk;

    function automatic int pick_gap(int pace);
        int r;
        if (pace == 0) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // insert one word into the list; a last word empties the list, posting it to pending_words when post is set
    function automatic void sort_word(logic [TAG_W-1:0] tag, logic [LEN_W-1:0] len,
                                      logic last, bit post);
        int pos;
        sorted_word_t w;
        if (list_cnt >= MAX_WORDS) begin
            list_drop = 1'b1;
        end else begin
            pos = list_cnt;
            while (pos > 0 && len < list_len[pos-1]) begin
                list_tag[pos] = list_tag[pos-1];
                list_len[pos] = list_len[pos-1];
                pos--;
            end
            list_tag[pos] = tag;
            list_len[pos] = len;
            list_cnt++;
        end
        if (last) begin
            for (int k = 0; k < list_cnt; k++) begin
                w.tag = list_tag[k];
                w.len = list_len[k];
                w.eol = (k + 1 == list_cnt);
                w.ovf = list_drop;
                if (post) pending_words.push_back(w);
            end
            list_cnt  = 0;
            list_drop = 1'b0;
        end
    endfunction

    task automatic send_word(logic [TAG_W-1:0] tag, logic [LEN_W-1:0] len, logic last,
                             bit typed, sorted_word_t want);
        int gap;
        gap = pick_gap(sender_pace);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_word_tag    <= tag;
        s_word_length <= len;
        s_last_word   <= last;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        if (typed) begin
            sort_word(tag, len, last, 1'b0);
            pending_words.push_back(want);
        end else begin
            sort_word(tag, len, last, 1'b1);
        end
    endtask

    task automatic send_run(int n, key_mode_e mode);
        logic [LEN_W-1:0] len;
        for (int i = 0; i < n; i++) begin
            case (mode)
                KEY_TIES:     len = LEN_W'($urandom_range(20, 23));
                KEY_EXTREMES: len = $urandom_range(0, 1) ? 6'd63 : 6'd0;
                KEY_DESCEND:  len = 6'(63 - (i % 64));
                default:      len = LEN_W'($urandom_range(0, 63));
            endcase
            send_word(TAG_W'($urandom_range(0, 255)), len, i == n - 1, 1'b0, '0);
        end
    endtask

    // receiver: random back-pressure, long hold-off on request, result check
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_words.size() == 0) begin
                    $error("unexpected result: tag %0h length %0d", m_sorted_tag,
                           m_sorted_length);
                    err_cnt++;
                end else begin
                    sorted_word_t w;
                    w = pending_words.pop_front();
                    if (m_sorted_tag !== w.tag) begin
                        $error("sorted_tag: expected %0h, got %0h", w.tag, m_sorted_tag);
                        err_cnt++;
                    end
                    if (m_sorted_length !== w.len) begin
                        $error("sorted_length: expected %0d, got %0d", w.len,
                               m_sorted_length);
                        err_cnt++;
                    end
                    if (m_end_of_list !== w.eol) begin
                        $error("end_of_list: expected %0b, got %0b", w.eol, m_end_of_list);
                        err_cnt++;
                    end
                    if (m_overflowed !== w.ovf) begin
                        $error("overflowed: expected %0b, got %0b", w.ovf, m_overflowed);
                        err_cnt++;
                    end
                end
            end
            if (hold_given < hold_asks) begin
                hold_given++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap(sink_pace);
            end
        end
    end

    initial begin
        #15_000_000;
        $display("stable_insertion_sort_by_length verification failed");
        $finish;
    end

    initial begin
        int waited;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_DIR; i++) begin
            send_word(dir_rows[i].tag, dir_rows[i].len, dir_rows[i].last,
                      dir_rows[i].typed, dir_rows[i].want);
        end

        // capacity: exact fit, then overflow with the last three words dropped,
        // then a run that must show the flag cleared
        sender_pace = 0;
        sink_pace   = 1;
        send_run(MAX_WORDS, KEY_DESCEND);
        sender_pace = 1;
        send_run(MAX_WORDS + 3, KEY_ANY);
        send_run(1, KEY_ANY);

        // receiver holds off while new words keep coming
        for (int h = 0; h < 2; h++) begin
            sender_pace = h;
            hold_asks++;
            send_run(5, KEY_ANY);
            send_run(4, KEY_TIES);
        end

        while (words_sent < NUM_DIR + RAND_ITEMS) begin
            sender_pace = ($urandom_range(0, 2) != 0) ? 1 : 0;
            sink_pace   = ($urandom_range(0, 2) != 0) ? 1 : 0;
            send_run(($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                 : $urandom_range(1, 8),
                     key_mode_e'($urandom_range(0, 3)));
        end
        s_valid <= 1'b0;

        waited = 0;
        while (pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_words.size() != 0) begin
            $error("%0d expected results never arrived", pending_words.size());
            err_cnt++;
        end

        if (err_cnt == 0) begin
            $display("stable_insertion_sort_by_length verification clean");
        end else begin
            $display("stable_insertion_sort_by_length verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/sisbl_pkg.sv
src/sisbl_datapath.sv
src/sisbl_ctrl.sv
src/stable_insertion_sort_by_length.sv
src/sisbl_checker.sv
sim/stable_insertion_sort_by_length_tb.sv
